>>> src/wgp_pkg.sv
`timescale 1ns / 1ps

package wgp_pkg;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;
	localparam int DEF_COORD_BITS = 16;

	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int SIZE_W     = 13;  // holds any grid size plus one
	localparam int HALF_W     = 13;
	localparam int DW         = 34;  // rotation datapath
	localparam int PW         = 50;  // rotation products
	localparam int ACC_W      = 52;  // screen accumulator, Q22
	localparam int FRAC       = 14;
	localparam int SCR_SHIFT  = 22;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ANGLE_X     = 3'd0,
		REG_ANGLE_Y     = 3'd1,
		REG_ANGLE_Z     = 3'd2,
		REG_GRID_WIDTH  = 3'd3,
		REG_GRID_HEIGHT = 3'd4,
		REG_SCALE       = 3'd5,
		REG_PAD_X       = 3'd6,
		REG_PAD_Y       = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [15:0] sx;
		logic signed [15:0] cx;
		logic signed [15:0] sy;
		logic signed [15:0] cy;
		logic signed [15:0] sz;
		logic signed [15:0] cz;
		logic [15:0]        scale;
		logic signed [13:0] base_x;
		logic signed [13:0] base_y;
		logic [HALF_W-1:0]  half_x;
		logic [HALF_W-1:0]  half_y;
	} wgp_cfg_t;

	localparam logic [14:0] SIN_ROM [0:90] = '{
		15'd0, 15'd286, 15'd572, 15'd857, 15'd1143, 15'd1428, 15'd1713, 15'd1997,
		15'd2280, 15'd2563, 15'd2845, 15'd3126, 15'd3406, 15'd3686, 15'd3964,
		15'd4240, 15'd4516, 15'd4790, 15'd5063, 15'd5334, 15'd5604, 15'd5872,
		15'd6138, 15'd6402, 15'd6664, 15'd6924, 15'd7182, 15'd7438, 15'd7692,
		15'd7943, 15'd8192, 15'd8438, 15'd8682, 15'd8923, 15'd9162, 15'd9397,
		15'd9630, 15'd9860, 15'd10087, 15'd10311, 15'd10531, 15'd10749, 15'd10963,
		15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176, 15'd12365,
		15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421, 15'd13583,
		15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466, 15'd14598,
		15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296, 15'd15396,
		15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897, 15'd15964,
		15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262, 15'd16294,
		15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
	};

	function automatic logic [8:0] wrap_deg(input logic [8:0] a);
		return (a >= 9'd360) ? 9'(a - 9'd360) : a;
	endfunction

	function automatic logic signed [15:0] sin_deg(input logic [8:0] a);
		logic [8:0] w;
		logic [15:0] v;
		w = wrap_deg(a);
		if (w <= 9'd90) begin
			v = {1'b0, SIN_ROM[7'(w)]};
			return $signed(v);
		end else if (w <= 9'd180) begin
			v = {1'b0, SIN_ROM[7'(9'd180 - w)]};
			return $signed(v);
		end else if (w <= 9'd270) begin
			v = {1'b0, SIN_ROM[7'(w - 9'd180)]};
			return -$signed(v);
		end else begin
			v = {1'b0, SIN_ROM[7'(9'd360 - w)]};
			return -$signed(v);
		end
	endfunction

	function automatic logic signed [15:0] cos_deg(input logic [8:0] a);
		logic [9:0] s;
		s = {1'b0, wrap_deg(a)} + 10'd90;
		if (s >= 10'd360)
			s = s - 10'd360;
		return sin_deg(9'(s));
	endfunction

endpackage

>>> src/wgp_ram.sv
`timescale 1ns / 1ps

module wgp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

>>> src/wgp_rotate.sv
`timescale 1ns / 1ps

module wgp_rotate #(
	parameter int MAX_WIDTH  = wgp_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = wgp_pkg::DEF_MAX_HEIGHT,
	parameter int COORD_BITS = wgp_pkg::DEF_COORD_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [$clog2(MAX_WIDTH)-1:0]      col,
	input  logic [$clog2(MAX_HEIGHT)-1:0]     row,
	input  logic signed [15:0]                z,
	input  wgp_pkg::wgp_cfg_t                 cfg,
	output logic                              done,
	output logic signed [COORD_BITS-1:0]      pt_x,
	output logic signed [COORD_BITS-1:0]      pt_y
);
	import wgp_pkg::*;

	localparam int CWH = $clog2(MAX_HEIGHT);
	localparam logic signed [ACC_W-1:0] CMAX =
		(ACC_W'(1) <<< (COORD_BITS - 1)) - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] CMIN = -CMAX - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] RND = (ACC_W'(1) <<< SCR_SHIFT) - ACC_W'(1);

	logic signed [15:0] sx, cx, sy, cy, sz, cz;
	logic signed [16:0] sc;
	logic signed [CWH:0] row_s;
	logic signed [ACC_W-1:0] bx, by;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [DW-1:0] x1_s1, y1_s1, z1_s1, y1_c, z1_c;
	logic signed [DW-1:0] x2_s2, y1_s2;
	logic signed [DW-1:0] x3_s3, y3_s3;
	logic signed [ACC_W-1:0] ax_s4, ay_s4, ax_c, ay_c;
	logic signed [PW-1:0] p2, p3x, p3y;
	logic signed [DW-1:0] dx, dy;
	logic signed [ACC_W-1:0] rx, ry, qx, qy;
	logic signed [COORD_BITS-1:0] sat_x, sat_y;

	assign sx = cfg.sx;
	assign cx = cfg.cx;
	assign sy = cfg.sy;
	assign cy = cfg.cy;
	assign sz = cfg.sz;
	assign cz = cfg.cz;
	assign sc = $signed({1'b0, cfg.scale});
	assign bx = ACC_W'(cfg.base_x) <<< SCR_SHIFT;
	assign by = ACC_W'(cfg.base_y) <<< SCR_SHIFT;
	assign row_s = $signed({1'b0, row});

	always_comb begin
		y1_c = row_s * cx - z * sx;
		z1_c = row_s * sx + z * cx;
		p2   = x1_s1 * cy + z1_s1 * sy;
		p3x  = x2_s2 * cz - y1_s2 * sz;
		p3y  = x2_s2 * sz + y1_s2 * cz;
		dx   = x3_s3 - $signed({1'b0, cfg.half_x, {FRAC{1'b0}}});
		dy   = y3_s3 - $signed({1'b0, cfg.half_y, {FRAC{1'b0}}});
		ax_c = dx * sc + bx;
		ay_c = dy * sc + by;
		// truncate toward zero, then clamp to the coordinate range
		rx   = ax_s4 + (ax_s4[ACC_W-1] ? RND : ACC_W'(0));
		ry   = ay_s4 + (ay_s4[ACC_W-1] ? RND : ACC_W'(0));
		qx   = rx >>> SCR_SHIFT;
		qy   = ry >>> SCR_SHIFT;
		sat_x = (qx > CMAX) ? CMAX[COORD_BITS-1:0] :
			(qx < CMIN) ? CMIN[COORD_BITS-1:0] : qx[COORD_BITS-1:0];
		sat_y = (qy > CMAX) ? CMAX[COORD_BITS-1:0] :
			(qy < CMIN) ? CMIN[COORD_BITS-1:0] : qy[COORD_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		x1_s1 <= DW'({col, {FRAC{1'b0}}});
		y1_s1 <= y1_c;
		z1_s1 <= z1_c;
		x2_s2 <= DW'(p2 >>> FRAC);
		y1_s2 <= y1_s1;
		x3_s3 <= DW'(p3x >>> FRAC);
		y3_s3 <= DW'(p3y >>> FRAC);
		ax_s4 <= ax_c;
		ay_s4 <= ay_c;
		if (v_s4) begin
			pt_x <= sat_x;
			pt_y <= sat_y;
		end
	end

	assign done = v_s5;

endmodule

>>> src/wireframe_grid_projector_unit.sv
`timescale 1ns / 1ps

// Wireframe grid projector. Heights enter in raster order on the input channel;
// the block tracks column and row, rotates each point about X, Y then Z by the
// programmed angles, scales it by the Q8.8 factor, centres it on the screen
// and emits up to two line segments per point: first the horizontal segment
// from the left neighbour, then the vertical segment from the point above,
// with last marking the final one. The first point of a row has no horizontal
// segment, the first row no vertical ones, and the first point of the grid no
// transaction at all. One point is in flight at a time: in_stall rises when a
// point is taken and falls once its segments have gone out, so no new point is
// taken while the five-stage rotate and scale pipeline works on one or while
// out_stall holds a segment. The previous row's screen points sit in a
// single-port-per-side row buffer RAM of MAX_WIDTH entries, read when a point
// is taken and rewritten when its projection is ready. Write the registers
// only while in_stall is low and no transaction is pending.

module wireframe_grid_projector_unit #(
	parameter int MAX_WIDTH  = wgp_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = wgp_pkg::DEF_MAX_HEIGHT,
	parameter int COORD_BITS = wgp_pkg::DEF_COORD_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [wgp_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [wgp_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [15:0]                   height,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [COORD_BITS-1:0]         start_x,
	output logic signed [COORD_BITS-1:0]         start_y,
	output logic signed [COORD_BITS-1:0]         end_x,
	output logic signed [COORD_BITS-1:0]         end_y,
	output logic                                 vertical,
	output logic                                 last
);
	import wgp_pkg::*;

	localparam int CWW = $clog2(MAX_WIDTH);
	localparam int CWH = $clog2(MAX_HEIGHT);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_HOR,
		ST_VER
	} state_t;

	state_t state_q;

	// configuration registers
	logic [8:0]         angle_x_q, angle_y_q, angle_z_q;
	logic [10:0]        grid_width_q, grid_height_q;
	logic [15:0]        scale_q;
	logic signed [12:0] pad_x_q, pad_y_q;

	logic [CWW-1:0] col_q, col_pre;
	logic [CWH-1:0] row_q, row_pre;
	logic [SIZE_W-1:0] w_eff, h_eff, row_inc, col_nx, row_nx;
	logic signed [COORD_BITS-1:0] left_x_q, left_y_q;

	wgp_cfg_t cfg;
	logic in_fire, out_fire, done;
	logic signed [COORD_BITS-1:0] pt_x, pt_y;
	logic [2*COORD_BITS-1:0] above;

	assign in_fire  = in_valid && !in_stall;
	assign out_fire = out_valid && !out_stall;
	assign in_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_x_q     <= '0;
			angle_y_q     <= '0;
			angle_z_q     <= '0;
			grid_width_q  <= 11'd1;
			grid_height_q <= 11'd1;
			scale_q       <= 16'd256;
			pad_x_q       <= '0;
			pad_y_q       <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_ANGLE_X:     angle_x_q     <= cfg_data[8:0];
				REG_ANGLE_Y:     angle_y_q     <= cfg_data[8:0];
				REG_ANGLE_Z:     angle_z_q     <= cfg_data[8:0];
				REG_GRID_WIDTH:  grid_width_q  <= cfg_data[10:0];
				REG_GRID_HEIGHT: grid_height_q <= cfg_data[10:0];
				REG_SCALE:       scale_q       <= cfg_data;
				REG_PAD_X:       pad_x_q       <= $signed(cfg_data[12:0]);
				REG_PAD_Y:       pad_y_q       <= $signed(cfg_data[12:0]);
				default: ;
			endcase
		end
	end

	// clamp the grid size to 1..MAX
	always_comb begin
		if (grid_width_q == 11'd0)
			w_eff = SIZE_W'(1);
		else if (SIZE_W'(grid_width_q) > SIZE_W'(MAX_WIDTH))
			w_eff = SIZE_W'(MAX_WIDTH);
		else
			w_eff = SIZE_W'(grid_width_q);
		if (grid_height_q == 11'd0)
			h_eff = SIZE_W'(1);
		else if (SIZE_W'(grid_height_q) > SIZE_W'(MAX_HEIGHT))
			h_eff = SIZE_W'(MAX_HEIGHT);
		else
			h_eff = SIZE_W'(grid_height_q);
	end

	// trig values and screen offsets follow the registers directly
	always_comb begin
		cfg.sx     = sin_deg(angle_x_q);
		cfg.cx     = cos_deg(angle_x_q);
		cfg.sy     = sin_deg(angle_y_q);
		cfg.cy     = cos_deg(angle_y_q);
		cfg.sz     = sin_deg(angle_z_q);
		cfg.cz     = cos_deg(angle_z_q);
		cfg.scale  = scale_q;
		cfg.base_x = 14'sd500 + 14'(pad_x_q);
		cfg.base_y = 14'sd400 + 14'(pad_y_q);
		cfg.half_x = HALF_W'(w_eff >> 1);
		cfg.half_y = HALF_W'(h_eff >> 1);
	end

	// wrap the counters against a grid that may have shrunk since the last point
	always_comb begin
		if (SIZE_W'(col_q) >= w_eff) begin
			col_pre = '0;
			row_inc = SIZE_W'(row_q) + SIZE_W'(1);
		end else begin
			col_pre = col_q;
			row_inc = SIZE_W'(row_q);
		end
		row_pre = (row_inc >= h_eff) ? '0 : CWH'(row_inc);
		col_nx  = SIZE_W'(col_q) + SIZE_W'(1);
		row_nx  = SIZE_W'(row_q) + SIZE_W'(1);
	end

	wgp_rotate #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.COORD_BITS(COORD_BITS)
	) u_rotate (
		.clk   (clk),
		.arst_n(arst_n),
		.start (in_fire),
		.col   (col_pre),
		.row   (row_pre),
		.z     (height),
		.cfg   (cfg),
		.done  (done),
		.pt_x  (pt_x),
		.pt_y  (pt_y)
	);

	// row buffer: read the point above on take, rewrite it when the projection lands
	wgp_ram #(
		.WIDTH(2 * COORD_BITS),
		.DEPTH(MAX_WIDTH)
	) u_row_buf (
		.clk  (clk),
		.we   (done),
		.waddr(col_q),
		.wdata({pt_x, pt_y}),
		.re   (in_fire),
		.raddr(col_pre),
		.rdata(above)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			col_q     <= '0;
			row_q     <= '0;
			left_x_q  <= '0;
			left_y_q  <= '0;
			out_valid <= 1'b0;
			start_x   <= '0;
			start_y   <= '0;
			end_x     <= '0;
			end_y     <= '0;
			vertical  <= 1'b0;
			last      <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						col_q   <= col_pre;
						row_q   <= row_pre;
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					if (done) begin
						end_x <= pt_x;
						end_y <= pt_y;
						if (col_q != '0) begin
							start_x   <= left_x_q;
							start_y   <= left_y_q;
							vertical  <= 1'b0;
							last      <= (row_q == '0);
							out_valid <= 1'b1;
							state_q   <= ST_HOR;
						end else if (row_q != '0) begin
							start_x   <= above[2*COORD_BITS-1:COORD_BITS];
							start_y   <= above[COORD_BITS-1:0];
							vertical  <= 1'b1;
							last      <= 1'b1;
							out_valid <= 1'b1;
							state_q   <= ST_VER;
						end else begin
							// first point of the grid: nothing to draw
							left_x_q <= pt_x;
							left_y_q <= pt_y;
							if (SIZE_W'(1) >= w_eff) begin
								col_q <= '0;
								row_q <= (row_nx >= h_eff) ? '0 : CWH'(row_nx);
							end else begin
								col_q <= CWW'(1);
							end
							state_q  <= ST_IDLE;
						end
					end
				end
				ST_HOR: begin
					if (out_fire) begin
						if (row_q != '0) begin
							start_x  <= above[2*COORD_BITS-1:COORD_BITS];
							start_y  <= above[COORD_BITS-1:0];
							vertical <= 1'b1;
							last     <= 1'b1;
							state_q  <= ST_VER;
						end else begin
							out_valid <= 1'b0;
							left_x_q  <= end_x;
							left_y_q  <= end_y;
							if (col_nx >= w_eff) begin
								col_q <= '0;
								row_q <= (row_nx >= h_eff) ? '0 : CWH'(row_nx);
							end else begin
								col_q <= CWW'(col_nx);
							end
							state_q   <= ST_IDLE;
						end
					end
				end
				ST_VER: begin
					if (out_fire) begin
						out_valid <= 1'b0;
						left_x_q  <= end_x;
						left_y_q  <= end_y;
						if (col_nx >= w_eff) begin
							col_q <= '0;
							row_q <= (row_nx >= h_eff) ? '0 : CWH'(row_nx);
						end else begin
							col_q <= CWW'(col_nx);
						end
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> src/wgp_checker.sv
`timescale 1ns / 1ps

module wgp_checker #(
	parameter int COORD_BITS = wgp_pkg::DEF_COORD_BITS
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic signed [COORD_BITS-1:0]  start_x,
	input logic signed [COORD_BITS-1:0]  end_x,
	input logic                          last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(start_x) && $stable(end_x)
			&& $stable(last))
		else $error("stalled result changed");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall && !out_valid)
		else $error("not busy after taking a point");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !out_valid)
		else $error("result pending while ready");

	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last |=> !out_valid && !in_stall)
		else $error("block not free after final segment");

endmodule

bind wireframe_grid_projector_unit wgp_checker #(.COORD_BITS(COORD_BITS)) u_wgp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_stall (in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.start_x  (start_x),
	.end_x    (end_x),
	.last     (last)
);
